FILE: design/mdlc_pkg.sv
// Shared types and constants for the modulated delay line with cubic interpolation.
`default_nettype none

package mdlc_pkg;

   localparam int DELAY_BITS     = 32;
   localparam int LIMIT_BITS     = 16;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_INDEX_BITS = 1;

   localparam logic [REG_INDEX_BITS-1:0] REG_MAX_DELAY   = 1'b0;
   localparam logic [LIMIT_BITS-1:0]     MAX_DELAY_RESET = 16'd65532;

   typedef struct packed {
      logic                     psel;
      logic                     penable;
      logic                     pwrite;
      logic [CSR_ADDR_BITS-1:0] paddr;
      logic [CSR_DATA_BITS-1:0] pwdata;
   } mdlc_apb_req_type;

endpackage

`default_nettype wire

FILE: design/mdlc_csr.sv
// Configuration register block holding the delay limit.
`default_nettype none

module mdlc_csr
   import mdlc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mdlc_apb_req_type         apb_req,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic      [LIMIT_BITS-1:0]    max_delay
);

   logic [LIMIT_BITS-1:0]     max_delay_ff;
   logic [LIMIT_BITS-1:0]     max_delay_in;
   logic [REG_INDEX_BITS-1:0] reg_index;
   logic                      wr_strobe;

   assign reg_index = apb_req.paddr[CSR_ADDR_BITS-1 -: REG_INDEX_BITS];
   assign wr_strobe = apb_req.psel && apb_req.penable && apb_req.pwrite;

   always_comb begin
      max_delay_in = max_delay_ff;
      if (wr_strobe && reg_index == REG_MAX_DELAY) begin
         max_delay_in = apb_req.pwdata[LIMIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_delay_ff <= MAX_DELAY_RESET;
      end else begin
         max_delay_ff <= max_delay_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_MAX_DELAY: prdata = CSR_DATA_BITS'(max_delay_ff);
         default:       prdata = '0;
      endcase
   end

   assign max_delay = max_delay_ff;

endmodule

`default_nettype wire

FILE: design/mdlc_tap_store.sv
// Circular sample store with one write port and one registered read port.
`default_nettype none

module mdlc_tap_store #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/modulated_delay_line_cubic_unit.sv
// Top level of the fractional delay line with Catmull-Rom cubic interpolation.
//
//  Channel   Direction  Handshake                 Contents
//  req_      in         req_tvalid/req_tready     sample_in, delay_q16
//  rsp_      out        rsp_tvalid/rsp_tready     sample_out
//  csr_      in/out     APB, pready always high   max_delay at byte address 0
//
// A request goes through a write, four store reads through the single read port
// and three passes through the shared multiplier; new ones wait for ST_IDLE.
// For a depth below 65536 a reciprocal-multiply remainder step, ST_MOD, is added.
// Reset is synchronous; the store needs no clearing pass, entries not yet
// written since reset read as zero. A waiting result stalls only ST_DONE.
`default_nettype none

module modulated_delay_line_cubic_unit
   import mdlc_pkg::*;
#(
   parameter int DEPTH       = 65536,
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire logic                                             req_tvalid,
   output logic                                                  req_tready,
   // sample_in, delay_q16
   input  wire logic [((SAMPLE_BITS+DELAY_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                                  rsp_tvalid,
   input  wire logic                                             rsp_tready,
   // sample_out
   output logic      [((SAMPLE_BITS+7)/8)*8-1:0]                 rsp_tdata,
   input  wire logic                                             csr_psel,
   input  wire logic                                             csr_penable,
   input  wire logic                                             csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]                         csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]                         csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0]                         csr_prdata,
   output logic                                                  csr_pready
);

   localparam int DW       = $clog2(DEPTH);
   localparam int OUT_W    = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int AW       = SAMPLE_BITS + 6;
   localparam int PW       = AW + FRAC_BITS + 1;
   localparam int CLW      = (DELAY_BITS > LIMIT_BITS + FRAC_BITS) ? DELAY_BITS
                                                                   : LIMIT_BITS + FRAC_BITS;
   localparam bit NEED_MOD = (DEPTH <= (1 << LIMIT_BITS) - 1);
   localparam int MQW      = 2 * LIMIT_BITS + 2;
   localparam int MOD_SH   = LIMIT_BITS + DW;

   localparam logic [DW:0]   DEP      = (DW + 1)'(DEPTH);
   localparam logic [DW-1:0] LAST_IDX = DW'(DEPTH - 1);

   localparam logic [MQW-1:0] MOD_MUL =
      MQW'(((64'(1) << MOD_SH) + 64'(DEPTH) - 64'(1)) / 64'(DEPTH));
   localparam logic [LIMIT_BITS-1:0] DEP_L = LIMIT_BITS'(DEPTH);

   localparam logic signed [AW-1:0] ONE_A  = $signed(AW'(1));
   localparam logic signed [AW-1:0] SAT_HI = $signed(AW'((64'(1) << (SAMPLE_BITS - 1)) - 1));
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - ONE_A;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRITE = 4'd1;
   localparam logic [3:0] ST_MOD   = 4'd2;
   localparam logic [3:0] ST_BASE  = 4'd3;
   localparam logic [3:0] ST_READ  = 4'd4;
   localparam logic [3:0] ST_COEF  = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_ACC   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   mdlc_apb_req_type      apb_req;
   logic [LIMIT_BITS-1:0] max_delay;

   logic [3:0]              state_ff, state_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [DW-1:0]           wp_ff, wp_in;
   logic                    wrapped_ff, wrapped_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [LIMIT_BITS-1:0]   di_ff, di_in;
   logic [FRAC_BITS-1:0]    t_ff, t_in;
   logic [LIMIT_BITS-1:0]   quot_ff, quot_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           rp_ff, rp_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic signed [SAMPLE_BITS-1:0] y_ff [4];
   logic signed [SAMPLE_BITS-1:0] y_in [4];
   logic signed [AW-1:0]    a_ff, a_in;
   logic signed [AW-1:0]    c2_ff, c2_in, c1_ff, c1_in, c0_ff, c0_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  rsp_sample_ff, rsp_sample_in;

   logic                    req_accept;
   logic [CLW-1:0]          delay_w, clamp_lo, clamp_hi, delay_c;
   logic [LIMIT_BITS-1:0]   lim;
   logic [MQW-1:0]          mod_prod;
   logic [DW:0]             base_t;
   logic [DW-1:0]           base_idx;
   logic                    store_we;
   logic [SAMPLE_BITS-1:0]  rd_data;
   logic signed [AW-1:0]    e0, e1, e2, e3, d12, coef_sel, a_half;
   logic signed [PW-1:0]    prod_shift;
   logic [1:0]              y_idx;

   assign apb_req.psel    = csr_psel;
   assign apb_req.penable = csr_penable;
   assign apb_req.pwrite  = csr_pwrite;
   assign apb_req.paddr   = csr_paddr;
   assign apb_req.pwdata  = csr_pwdata;
   assign csr_pready      = 1'b1;

   mdlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .apb_req   (apb_req),
      .prdata    (csr_prdata),
      .max_delay (max_delay)
   );

   mdlc_tap_store #(
      .DEPTH (DEPTH),
      .WIDTH (SAMPLE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign store_we   = (state_ff == ST_WRITE);

   always_comb begin
      delay_w  = CLW'(req_tdata[SAMPLE_BITS +: DELAY_BITS]);
      lim      = (max_delay == '0) ? LIMIT_BITS'(1) : max_delay;
      clamp_lo = CLW'(1) << FRAC_BITS;
      clamp_hi = CLW'(lim) << FRAC_BITS;
      delay_c  = delay_w;
      if (delay_c < clamp_lo) begin
         delay_c = clamp_lo;
      end
      if (delay_c > clamp_hi) begin
         delay_c = clamp_hi;
      end
   end

   always_comb begin
      mod_prod = MQW'(di_ff) * MOD_MUL;
      base_t   = (wp_ff >= rem_ff) ? (DW + 1)'(wp_ff) - (DW + 1)'(rem_ff)
                                   : (DW + 1)'(wp_ff) + DEP - (DW + 1)'(rem_ff);
      base_idx = (DW'(base_t) == LAST_IDX) ? '0 : DW'(base_t) + DW'(1);
   end

   always_comb begin
      e0  = AW'(y_ff[0]);
      e1  = AW'(y_ff[1]);
      e2  = AW'(y_ff[2]);
      e3  = AW'(y_ff[3]);
      d12 = e1 - e2;
      case (cnt_ff)
         4'd0:    coef_sel = c2_ff;
         4'd1:    coef_sel = c1_ff;
         default: coef_sel = c0_ff;
      endcase
      prod_shift = prod_ff >>> FRAC_BITS;
      a_half     = (a_ff + ONE_A) >>> 1;
      y_idx      = 2'(cnt_ff - 4'd1);
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      wp_in         = wp_ff;
      wrapped_in    = wrapped_ff;
      sample_in     = sample_ff;
      di_in         = di_ff;
      t_in          = t_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      rp_in         = rp_ff;
      rd_ok_in      = wrapped_ff || (rp_ff <= wp_ff);
      y_in          = y_ff;
      a_in          = a_ff;
      c2_in         = c2_ff;
      c1_in         = c1_ff;
      c0_in         = c0_ff;
      prod_in       = a_ff * $signed({1'b0, t_ff});
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               di_in     = LIMIT_BITS'(delay_c >> FRAC_BITS);
               t_in      = FRAC_BITS'(delay_c);
               state_in  = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cnt_in = '0;
            if (NEED_MOD) begin
               state_in = ST_MOD;
            end else begin
               rem_in   = DW'(di_ff);
               state_in = ST_BASE;
            end
         end
         ST_MOD: begin
            if (cnt_ff == 4'd0) begin
               quot_in = LIMIT_BITS'(mod_prod >> MOD_SH);
               cnt_in  = 4'd1;
            end else begin
               rem_in   = DW'(di_ff - LIMIT_BITS'(quot_ff * DEP_L));
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            rp_in    = base_idx;
            cnt_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            rp_in  = (rp_ff == '0) ? LAST_IDX : rp_ff - DW'(1);
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff != 4'd0) begin
               y_in[y_idx] = rd_ok_ff ? $signed(rd_data) : '0;
            end
            if (cnt_ff == 4'd4) begin
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            a_in       = e3 - e0 + (d12 <<< 1) + d12;
            c2_in      = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            c1_in      = e2 - e0;
            c0_in      = e1 <<< 1;
            wp_in      = (wp_ff == LAST_IDX) ? '0 : wp_ff + DW'(1);
            wrapped_in = wrapped_ff || (wp_ff == LAST_IDX);
            cnt_in     = '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            a_in   = AW'(prod_shift) + coef_sel;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (a_half > SAT_HI) begin
                  rsp_sample_in = SAMPLE_BITS'(SAT_HI);
               end else if (a_half < SAT_LO) begin
                  rsp_sample_in = SAMPLE_BITS'(SAT_LO);
               end else begin
                  rsp_sample_in = SAMPLE_BITS'(a_half);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      di_ff         <= di_in;
      t_ff          <= t_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      rp_ff         <= rp_in;
      rd_ok_ff      <= rd_ok_in;
      y_ff          <= y_in;
      a_ff          <= a_in;
      c2_ff         <= c2_in;
      c1_ff         <= c1_in;
      c0_ff         <= c0_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(rsp_sample_ff);

endmodule

`default_nettype wire

FILE: bench/modulated_delay_line_cubic_unit_tb.sv
// Self-checking testbench for the cubic-interpolated modulated delay line.
`default_nettype none

module modulated_delay_line_cubic_unit_tb;
   import mdlc_pkg::*;

   localparam int SAMPLE_W = 24;
   localparam int FRAC_W   = 16;
   localparam int REQ_W    = ((SAMPLE_W + DELAY_BITS + 7) / 8) * 8;
   localparam int RSP_W    = ((SAMPLE_W + 7) / 8) * 8;

   localparam logic [CSR_ADDR_BITS-1:0] ADDR_MAX_DELAY = {REG_MAX_DELAY, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_SPARE     = 3'b100;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   sample;
      logic [DELAY_BITS-1:0] delay;
      logic                  drain;
   } request_t;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   // sample_in, delay_q16
   logic [REQ_W-1:0]         req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   // sample_out
   logic [RSP_W-1:0]         rsp_tdata;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   request_t            pending_requests[$];
   logic [SAMPLE_W-1:0] expected_samples[$];

   logic signed [SAMPLE_W-1:0] history [65536];
   logic [15:0]                write_ptr;
   logic [LIMIT_BITS-1:0]      delay_limit;

   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;
   int unsigned errors;

   modulated_delay_line_cubic_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic logic [SAMPLE_W-1:0] interpolate_delayed(input logic [SAMPLE_W-1:0] smp,
                                                               input logic [DELAY_BITS-1:0] dly);
      logic [15:0] lim;
      logic [15:0] di;
      logic [15:0] k;
      logic [31:0] d;
      logic [31:0] hi;
      longint      t;
      longint      y0;
      longint      y1;
      longint      y2;
      longint      y3;
      longint      a;
      history[write_ptr] = smp;
      lim = (delay_limit == 0) ? 16'd1 : delay_limit;
      hi = {lim, 16'h0000};
      d = dly;
      if (d < 32'h0001_0000) d = 32'h0001_0000;
      if (d > hi) d = hi;
      di = d[31:16];
      t = longint'(d[FRAC_W-1:0]);
      k = write_ptr - di + 16'd1;
      y0 = history[k];
      k = write_ptr - di;
      y1 = history[k];
      k = write_ptr - di - 16'd1;
      y2 = history[k];
      k = write_ptr - di - 16'd2;
      y3 = history[k];
      a = (y3 - y0) + 3 * (y1 - y2);
      a = ((a * t) >>> FRAC_W) + (2 * y0 - 5 * y1 + 4 * y2 - y3);
      a = ((a * t) >>> FRAC_W) + (y2 - y0);
      a = ((a * t) >>> FRAC_W) + 2 * y1;
      a = (a + 1) >>> 1;
      if (a > 64'sd8388607) a = 64'sd8388607;
      if (a < -64'sd8388608) a = -64'sd8388608;
      write_ptr = write_ptr + 16'd1;
      return a[SAMPLE_W-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int unsigned pick;
      logic [31:0] r;
      pick = $urandom_range(99);
      r = $urandom();
      if (pick < 5) return SAMPLE_MAX;
      if (pick < 10) return SAMPLE_MIN;
      if (pick < 13) return '0;
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic logic [DELAY_BITS-1:0] random_delay(input logic [LIMIT_BITS-1:0] lim);
      int unsigned pick;
      int unsigned top;
      int unsigned near;
      logic [31:0] r;
      pick = $urandom_range(99);
      top = (lim == 0) ? 1 : lim;
      near = (top < 48) ? top : 48;
      r = $urandom();
      if (pick < 45) return {16'($urandom_range(near, 1)), r[15:0]};
      if (pick < 60) return {16'($urandom_range(top, 1)), r[15:0]};
      if (pick < 70) return r;
      if (pick < 78) return {16'h0000, r[15:0]};
      if (pick < 86) return {16'($urandom_range(top, 1)), 16'h0000};
      if (pick < 93) return {16'($urandom_range(65535, top)), r[15:0]};
      return {16'($urandom_range(near, 1)), 16'hFFFF};
   endfunction

   task automatic flag_error(input string what, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
      if (errors < 10)
         $display("ERROR %s: expected %h, got %h", what, want, got);
      errors++;
   endtask

   task automatic queue_request(input logic [SAMPLE_W-1:0] smp, input logic [DELAY_BITS-1:0] dly,
                                input logic drain);
      request_t r;
      r.sample = smp;
      r.delay  = dly;
      r.drain  = drain;
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_samples.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[CSR_ADDR_BITS-1:2] == REG_MAX_DELAY)
         delay_limit = data[LIMIT_BITS-1:0];
   endtask

   task automatic run_phase(input logic [CSR_DATA_BITS-1:0] limit_word,
                            input int unsigned gap_pct, input int unsigned stall_pct,
                            input int count);
      wait_drained();
      csr_write(ADDR_MAX_DELAY, limit_word);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++)
         queue_request(random_sample(), random_delay(delay_limit), $urandom_range(39) == 0);
   endtask

   always @(posedge clock) begin : drive_requests
      request_t nxt;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_samples.push_back(interpolate_delayed(req_tdata[SAMPLE_W-1:0],
                                                           req_tdata[SAMPLE_W +: DELAY_BITS]));
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct &&
                !(pending_requests[0].drain && expected_samples.size() != 0)) begin
               nxt = pending_requests.pop_front();
               req_tdata  <= {nxt.delay, nxt.sample};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_results
      logic [SAMPLE_W-1:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               flag_error("unexpected result", '0, rsp_tdata[SAMPLE_W-1:0]);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[SAMPLE_W-1:0] !== want)
                  flag_error("sample_out mismatch", want, rsp_tdata[SAMPLE_W-1:0]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int guard;
      foreach (history[i]) history[i] = '0;
      write_ptr      = '0;
      delay_limit    = MAX_DELAY_RESET;
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      errors         = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_request(SAMPLE_MAX, 32'h0000_0000, 1'b0);
      queue_request(SAMPLE_MIN, 32'h0001_0000, 1'b0);
      queue_request(SAMPLE_MAX, 32'h0001_8000, 1'b0);
      queue_request(SAMPLE_MIN, 32'h0001_8000, 1'b0);
      queue_request(SAMPLE_MAX, 32'h0002_8000, 1'b0);
      queue_request(SAMPLE_MIN, 32'h0001_FFFF, 1'b0);
      queue_request(SAMPLE_MAX, 32'h0001_0001, 1'b0);
      queue_request('0, 32'h0000_FFFF, 1'b0);
      queue_request(SAMPLE_MIN, 32'h0003_4000, 1'b0);
      queue_request(24'h000001, 32'h0002_C000, 1'b0);
      queue_request(24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_request(24'h555555, 32'hFFFC_0000, 1'b0);
      queue_request(24'hAAAAAA, 32'hFFFC_0001, 1'b0);
      queue_request(24'h123456, 32'hFFFB_FFFF, 1'b0);
      queue_request(SAMPLE_MAX, 32'h0004_0000, 1'b1);
      queue_request(SAMPLE_MIN, 32'h000C_8000, 1'b0);
      queue_request(SAMPLE_MAX, 32'h0001_8000, 1'b0);
      queue_request(SAMPLE_MIN, 32'h0002_7FFF, 1'b0);
      queue_request(24'h400000, 32'h0010_0000, 1'b0);
      queue_request(24'hC00000, 32'h0000_8000, 1'b0);

      run_phase(32'd40, 62, 0, 120);
      run_phase(32'd0, 0, 62, 60);
      run_phase(32'd65535, 38, 38, 130);
      run_phase(32'd1, 0, 0, 60);
      wait_drained();
      csr_write(ADDR_SPARE, $urandom());
      run_phase(32'd300, 62, 0, 130);
      run_phase(32'hABCD_FFFC, 0, 62, 130);
      run_phase(32'($urandom_range(64, 2)), 38, 38, 130);
      run_phase(32'd8, 0, 0, 130);

      for (guard = 0; guard < 50000 && (pending_requests.size() != 0 || req_tvalid ||
           expected_samples.size() != 0); guard++)
         @(negedge clock);
      repeat (40) @(posedge clock);
      if (expected_samples.size() != 0)
         flag_error("results missing", '0, '0);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
design/mdlc_pkg.sv
design/mdlc_csr.sv
design/mdlc_tap_store.sv
design/modulated_delay_line_cubic_unit.sv
bench/modulated_delay_line_cubic_unit_tb.sv
